/* hdl/prct_pkg.sv */
// ----------------------------------------------------------------------------
// prct_pkg: shared types and constants of the play count ranked table
// Request and result words, one stored entry, and the broadcast that drives
// every cell of the chain.
// ----------------------------------------------------------------------------
package prct_pkg;

  // operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // saturation point of a play count
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  // request word
  typedef struct packed {
    logic        operation;
    logic [31:0] key;
    logic [23:0] hour_stamp;
    logic [5:0]  rank_index;
  } request_t;

  // result word
  typedef struct packed {
    logic [6:0]  rank;
    logic [23:0] play_count;
    logic [31:0] key_out;
    logic [23:0] hour_out;
    logic        entry_valid;
    logic        evicted;
    logic [31:0] evicted_key;
  } result_t;

  // one ranked entry
  typedef struct packed {
    logic [31:0] key;
    logic [23:0] count;
    logic [23:0] hour;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [31:0] probe_key;  // key looked up in the first step
    entry_t      fresh;      // entry to place in the second step
    logic        found;      // the recorded key was already present
    logic        upd;        // apply the insert and shift this cycle
  } cell_ctl_t;

endpackage

/* hdl/play_count_ranked_table.sv */
// ----------------------------------------------------------------------------
// play_count_ranked_table: entries ranked by play count, highest first
// A record bumps or creates an entry and moves it to its rank, evicting the
// tail of a full table; a read returns the entry at a given rank.
// ----------------------------------------------------------------------------
//
//  channel   signals                 word type            flow
//  request   start, busy, request    prct_pkg::request_t  taken when start & !busy
//  result    done, result            prct_pkg::result_t   one cycle, no back-pressure
//
// An item passes the step-one, step-two and result registers, and its result
// word is on the result port for one cycle; the next can be taken in step two.
// Step one compares the key in every cell and gathers the hit entry; step two
// compares counts in every cell and inserts or shifts along the chain.
// Reset clears the occupancy and control; entries are undefined until written.
// The result side cannot stall; busy is high only during step one.
//
module play_count_ranked_table #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  prct_pkg::request_t request,
  output logic               done,
  output prct_pkg::result_t  result
);

  localparam int IW = $clog2(DEPTH + 1);

  // step one registers
  logic        s1_busy;
  logic        s1_op;
  logic [31:0] s1_key;
  logic [23:0] s1_hour;
  logic [5:0]  s1_ridx;

  // step two registers
  logic             s2_go;
  logic             s2_op;
  logic [31:0]      s2_key;
  logic [23:0]      s2_hour;
  logic [5:0]       s2_ridx;
  logic             s2_found;
  prct_pkg::entry_t s2_entry;
  logic [IW-1:0]    s2_midx;
  logic [23:0]      s2_cnt;

  logic [IW-1:0] occ;

  // chain signals
  prct_pkg::cell_ctl_t ctl;
  prct_pkg::entry_t    cell_entry [DEPTH];
  prct_pkg::entry_t    prev_entry [DEPTH];
  logic [DEPTH-1:0]    prev_ins;
  logic [DEPTH-1:0]    match_vec;
  logic [DEPTH-1:0]    ins_vec;
  logic [DEPTH-1:0]    at_pos_vec;
  logic [DEPTH-1:0]    sel_vec;

  // gathered values
  prct_pkg::entry_t g_entry;
  logic [IW-1:0]    g_idx;
  logic             g_any;
  logic [23:0]      cnt_next;
  logic [IW-1:0]    pos;
  logic             kept;
  logic             full;
  logic             accept;

  assign accept = start && !s1_busy;
  assign busy   = s1_busy;
  assign full   = occ == IW'(DEPTH);

  // broadcast to the cells
  assign ctl.probe_key   = s1_key;
  assign ctl.fresh.key   = s2_key;
  assign ctl.fresh.count = s2_cnt;
  assign ctl.fresh.hour  = s2_hour;
  assign ctl.found       = s2_found;
  assign ctl.upd         = s2_go && (s2_op == prct_pkg::OP_RECORD);

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_entry[i] = '0;
      assign prev_ins[i]   = 1'b0;
    end else begin : g_link
      assign prev_entry[i] = cell_entry[i-1];
      assign prev_ins[i]   = ins_vec[i-1];
    end

    prct_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .midx       (s2_midx),
      .prev_entry (prev_entry[i]),
      .prev_ins   (prev_ins[i]),
      .entry      (cell_entry[i]),
      .match      (match_vec[i]),
      .ins        (ins_vec[i]),
      .at_pos     (at_pos_vec[i])
    );
  end

  // step one: select the hit rank for a record or the addressed rank for a read
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (s1_op == prct_pkg::OP_READ) begin
        sel_vec[i] = (i < int'(occ)) && (i == int'(s1_ridx));
      end else begin
        sel_vec[i] = match_vec[i];
      end
    end
  end

  // one-hot gather of the selected entry and its rank
  always_comb begin
    g_entry = '0;
    g_idx   = '0;
    g_any   = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_vec[i]) begin
        g_entry = prct_pkg::entry_t'(g_entry | cell_entry[i]);
        g_idx   = g_idx | IW'(i);
        g_any   = 1'b1;
      end
    end
  end

  // new count, saturating
  always_comb begin
    if (!g_any) begin
      cnt_next = 24'd1;
    end else if (g_entry.count == prct_pkg::CNT_MAX) begin
      cnt_next = prct_pkg::CNT_MAX;
    end else begin
      cnt_next = g_entry.count + 24'd1;
    end
  end

  // step two: encode the insertion rank
  always_comb begin
    pos  = '0;
    kept = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (at_pos_vec[i]) begin
        pos  = pos | IW'(i);
        kept = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
      s2_go   <= 1'b0;
      done    <= 1'b0;
      occ     <= '0;
    end else begin
      s1_busy <= accept;
      s2_go   <= s1_busy;
      done    <= s2_go;
      if (ctl.upd && kept && !s2_found && !full) begin
        occ <= occ + IW'(1);
      end
    end
  end

  // step one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= request.operation;
      s1_key  <= request.key;
      s1_hour <= request.hour_stamp;
      s1_ridx <= request.rank_index;
    end
  end

  // step two payload
  always_ff @(posedge clk) begin
    if (s1_busy) begin
      s2_op    <= s1_op;
      s2_key   <= s1_key;
      s2_hour  <= s1_hour;
      s2_ridx  <= s1_ridx;
      s2_found <= g_any;
      s2_entry <= g_entry;
      s2_midx  <= g_idx;
      s2_cnt   <= cnt_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (s2_go) begin
      if (s2_op == prct_pkg::OP_READ) begin
        result.rank        <= {1'b0, s2_ridx};
        result.play_count  <= s2_entry.count;
        result.key_out     <= s2_entry.key;
        result.hour_out    <= s2_entry.hour;
        result.entry_valid <= s2_found;
        result.evicted     <= 1'b0;
        result.evicted_key <= '0;
      end else begin
        result.rank        <= kept ? 7'(pos) : 7'(DEPTH);
        result.play_count  <= s2_cnt;
        result.key_out     <= s2_key;
        result.hour_out    <= s2_hour;
        result.entry_valid <= kept;
        result.evicted     <= kept && !s2_found && full;
        result.evicted_key <= (kept && !s2_found && full) ? cell_entry[DEPTH-1].key : '0;
      end
    end
  end

  // occupancy stays within the table
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= IW'(DEPTH))
    else $error("occupancy above table depth");

  // a key is held at most once
  a_no_dup: assert property (@(posedge clk) disable iff (rst)
    s1_busy && (s1_op == prct_pkg::OP_RECORD) |-> $onehot0(match_vec))
    else $error("key matched in more than one rank");

  // a single insertion point along the chain
  a_one_pos: assert property (@(posedge clk) disable iff (rst)
    $onehot0(at_pos_vec))
    else $error("more than one insertion point");

  // an eviction only comes with a kept entry
  a_evict_kept: assert property (@(posedge clk) disable iff (rst)
    done && result.evicted |-> result.entry_valid)
    else $error("eviction without a kept entry");

  // occupancy grows by one at most, and only after a record
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(occ) |-> (occ == $past(occ) + IW'(1)) && $past(ctl.upd))
    else $error("occupancy changed unexpectedly");

endmodule

/* hdl/prct_cell.sv */
// ----------------------------------------------------------------------------
// prct_cell: one rank position of the ranked table
// Holds one entry, matches the broadcast key, and on update takes the new
// entry, takes the entry of the rank above it, or keeps its own.
// ----------------------------------------------------------------------------
module prct_cell #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0,
  localparam int IW   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  prct_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]       occ,
  input  logic [IW-1:0]       midx,
  input  prct_pkg::entry_t    prev_entry,
  input  logic                prev_ins,
  output prct_pkg::entry_t    entry,
  output logic                match,
  output logic                ins,
  output logic                at_pos
);

  logic [IW-1:0] my_idx;
  logic          valid;
  logic          below_match;

  assign my_idx = IW'(IDX);
  assign valid  = my_idx < occ;

  // key lookup
  assign match = valid && (entry.key == ctl.probe_key);

  // insertion point: list is sorted, so this is a thermometer along the chain
  assign ins    = !valid || (entry.count <= ctl.fresh.count);
  assign at_pos = ins && !prev_ins;

  // ranks past the removed entry keep their place
  assign below_match = ctl.found && (my_idx > midx);

  // insert or shift down by one rank
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      if (at_pos) begin
        entry <= ctl.fresh;
      end else if (prev_ins && !below_match) begin
        entry <= prev_entry;
      end
    end
  end

endmodule

/* tb/play_count_ranked_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// play_count_ranked_table_checker: result checker for the ranked play table
// Watches the request and result channels, keeps its own ranked list of
// keys, counts and hour stamps, predicts the result word of every accepted
// request word and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module play_count_ranked_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  prct_pkg::request_t request,
  input  logic               done,
  input  prct_pkg::result_t  result,
  output int                 errors,
  output int                 pending
);

  // predicted table contents, rank 0 first
  logic [31:0] keys_by_rank   [DEPTH];
  logic [23:0] counts_by_rank [DEPTH];
  logic [23:0] hours_by_rank  [DEPTH];
  int          filled;

  // result words still to come, oldest first
  prct_pkg::result_t outcome_q [$];
  prct_pkg::result_t want_word;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // apply one request word to the predicted table and return its result word
  function automatic prct_pkg::result_t play_outcome(prct_pkg::request_t w);
    prct_pkg::result_t r;
    int                i;
    int                hit;
    int                pos;
    logic [23:0]       cnt;
    r = '0;

    // read: entry at the given rank, zeros past the occupied part
    if (w.operation == prct_pkg::OP_READ) begin
      r.rank = {1'b0, w.rank_index};
      if (int'(w.rank_index) < filled) begin
        r.play_count  = counts_by_rank[w.rank_index];
        r.key_out     = keys_by_rank[w.rank_index];
        r.hour_out    = hours_by_rank[w.rank_index];
        r.entry_valid = 1'b1;
      end
      return r;
    end

    // look the key up from rank 0; a hit leaves the list with its count bumped
    cnt = 24'd1;
    hit = -1;
    i   = 0;
    while (hit < 0 && i < filled) begin
      if (keys_by_rank[i] == w.key) hit = i;
      i++;
    end
    if (hit >= 0) begin
      cnt = (counts_by_rank[hit] == prct_pkg::CNT_MAX) ? prct_pkg::CNT_MAX :
            counts_by_rank[hit] + 24'd1;
      for (i = hit; i < filled - 1; i++) begin
        keys_by_rank[i]   = keys_by_rank[i + 1];
        counts_by_rank[i] = counts_by_rank[i + 1];
        hours_by_rank[i]  = hours_by_rank[i + 1];
      end
      filled--;
    end

    // slot is ahead of the first entry whose count is not greater
    pos = filled;
    i   = 0;
    while (pos == filled && i < filled) begin
      if (counts_by_rank[i] <= cnt) pos = i;
      i++;
    end

    r.play_count = cnt;
    r.key_out    = w.key;
    r.hour_out   = w.hour_stamp;

    // full table: drop the play if it ranks last, else push the tail out
    if (filled == DEPTH) begin
      if (pos == DEPTH) begin
        r.rank = 7'(DEPTH);
        return r;
      end
      r.evicted     = 1'b1;
      r.evicted_key = keys_by_rank[DEPTH - 1];
      filled--;
    end

    for (i = filled; i > pos; i--) begin
      keys_by_rank[i]   = keys_by_rank[i - 1];
      counts_by_rank[i] = counts_by_rank[i - 1];
      hours_by_rank[i]  = hours_by_rank[i - 1];
    end
    keys_by_rank[pos]   = w.key;
    counts_by_rank[pos] = cnt;
    hours_by_rank[pos]  = w.hour_stamp;
    filled++;

    r.rank        = 7'(pos);
    r.entry_valid = 1'b1;
    return r;
  endfunction

  // count and report every mismatch
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // compare result words first, then queue the prediction for a new word
  always @(posedge clk) begin
    if (rst) begin
      filled = 0;
      outcome_q.delete();
    end else begin
      if (done !== 1'b0) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $error("result word with nothing expected");
        end else begin
          want_word = outcome_q.pop_front();
          check_field("rank", 32'(want_word.rank), 32'(result.rank));
          check_field("play_count", 32'(want_word.play_count), 32'(result.play_count));
          check_field("key_out", want_word.key_out, result.key_out);
          check_field("hour_out", 32'(want_word.hour_out), 32'(result.hour_out));
          check_field("entry_valid", 32'(want_word.entry_valid), 32'(result.entry_valid));
          check_field("evicted", 32'(want_word.evicted), 32'(result.evicted));
          check_field("evicted_key", want_word.evicted_key, result.evicted_key);
        end
      end
      if (start && !busy) outcome_q = {outcome_q, play_outcome(request)};
    end
    pending <= outcome_q.size();
  end

endmodule

/* tb/play_count_ranked_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// play_count_ranked_table_tb: testbench top for the ranked play table
// Drives record and read words with random gaps: directed corner words, a
// long churn phase with hot keys and fresh keys that keeps evictions going,
// then a phase that fills the table with repeated keys so new plays are
// dropped. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module play_count_ranked_table_tb;

  localparam int DEPTH      = 64;
  localparam int LIMIT      = 400000;
  localparam int CHURN_WORDS = 800;

  // idling styles of the sender
  localparam int NO_GAPS    = 0;
  localparam int SHORT_GAPS = 1;
  localparam int MIXED_GAPS = 2;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  prct_pkg::request_t request;
  logic               done;
  prct_pkg::result_t  result;
  int                 errors;
  int                 pending;
  int                 cycles;
  int                 sent;

  logic [31:0] hot_keys [12];
  logic [31:0] recent_keys [$];
  logic [31:0] paired_keys [$];

  play_count_ranked_table #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  play_count_ranked_table_checker #(.DEPTH(DEPTH)) rank_check (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // gap length before a word, by idling style
  function automatic int gap_for(int mode);
    int roll;
    roll = $urandom_range(0, 19);
    if (mode == NO_GAPS) return 0;
    if (mode == SHORT_GAPS) return (roll < 5) ? $urandom_range(1, 3) : 0;
    if (roll == 0) return $urandom_range(10, 40);
    return (roll < 6) ? $urandom_range(1, 3) : 0;
  endfunction

  // hold start low over a gap of length n with junk on the request port
  task automatic rest(int n);
    logic [63:0] junk;
    repeat (n) begin
      junk = {$urandom, $urandom};
      @(negedge clk);
      start   <= 1'b0;
      request <= junk[62:0];
    end
  endtask

  // send one word and wait until the block takes it
  task automatic issue(input int mode, input logic op, input logic [31:0] k,
                       input logic [23:0] h, input logic [5:0] idx);
    prct_pkg::request_t w;
    int                 gap;
    gap = gap_for(mode);
    if (gap > 0) rest(gap);
    w.operation  = op;
    w.key        = k;
    w.hour_stamp = h;
    w.rank_index = idx;
    @(negedge clk);
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  task automatic read_any(int mode);
    issue(mode, prct_pkg::OP_READ, $urandom, 24'($urandom), 6'($urandom));
  endtask

  task automatic record_key(int mode, logic [31:0] k);
    issue(mode, prct_pkg::OP_RECORD, k, 24'($urandom), 6'($urandom));
  endtask

  // stop sending until every expected result word has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          mode;
    int          len;
    int          roll;
    logic [31:0] k;

    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    sent    = 0;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty reads, key and hour extremes, hits, equal-count placement
    issue(NO_GAPS, prct_pkg::OP_READ, 32'h0, 24'h0, 6'd0);
    issue(NO_GAPS, prct_pkg::OP_READ, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'h0, 24'h0, 6'd0);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'h0, 24'h00_0001, 6'd0);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'h5555_5555, 24'hAA_AAAA, 6'h2A);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'hAAAA_AAAA, 24'h55_5555, 6'h15);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'hFFFF_FFFF, 24'h80_0000, 6'd1);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'hFFFF_FFFF, 24'h7F_FFFF, 6'd2);
    issue(NO_GAPS, prct_pkg::OP_RECORD, 32'h5555_5555, 24'h00_0000, 6'd3);
    for (int r = 0; r < 5; r++) issue(NO_GAPS, prct_pkg::OP_READ, 32'h0, 24'h0, 6'(r));
    issue(NO_GAPS, prct_pkg::OP_READ, 32'h0, 24'h0, 6'd63);
    drain();

    // churn: hot keys climb, fresh keys enter at count one and push the tail out
    while (sent < CHURN_WORDS) begin
      mode = $urandom_range(NO_GAPS, MIXED_GAPS);
      len  = $urandom_range(16, 40);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          read_any(mode);
        end else if (roll < 50) begin
          record_key(mode, hot_keys[$urandom_range(0, 11)]);
        end else if (roll < 55 && recent_keys.size() > 0) begin
          record_key(mode, recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
        end else begin
          k = $urandom;
          record_key(mode, k);
          recent_keys = {recent_keys, k};
          if (recent_keys.size() > 8) void'(recent_keys.pop_front());
        end
      end
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();

    // saturate: every key played twice leaves no count-one entry behind
    for (int p = 0; p < DEPTH; p++) begin
      k = $urandom;
      paired_keys = {paired_keys, k};
      record_key(SHORT_GAPS, k);
      record_key(SHORT_GAPS, k);
    end
    // new keys now rank below every entry and are dropped
    repeat (4) record_key(MIXED_GAPS, $urandom);
    for (int r = 0; r < DEPTH; r++) begin
      issue(SHORT_GAPS, prct_pkg::OP_READ, $urandom, 24'($urandom), 6'(r));
    end

    // hits on paired keys in the full table, mixed with dropped plays and reads
    repeat (40) begin
      roll = $urandom_range(0, 3);
      if (roll < 2) record_key(MIXED_GAPS, paired_keys[$urandom_range(0, DEPTH - 1)]);
      else if (roll == 2) record_key(MIXED_GAPS, $urandom);
      else read_any(MIXED_GAPS);
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
